/* rtl/dd_pkg.sv */
package dd_pkg;

  localparam int MAX_PROCS_DEF  = 16;
  localparam int MAX_RES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 12;

  localparam int PROC_W = 4;
  localparam int RES_W  = 4;
  localparam int AMT_W  = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0]  CFG_NUM_PROCS = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_NUM_RES   = 1'd1;
  localparam logic [CFG_DATA_W-1:0] NUM_PROCS_RST = 5'd16;
  localparam logic [CFG_DATA_W-1:0] NUM_RES_RST   = 5'd16;

  localparam logic MAT_SEL_ALLOC = 1'b0;
  localparam logic MAT_SEL_REQ   = 1'b1;
  localparam logic VEC_SEL_AVAIL = 1'b0;
  localparam logic VEC_SEL_WORK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_AVAIL = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_REQ   = 2'd2,
    KIND_RUN   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_SCAN,
    ST_RELEASE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [PROC_W-1:0] proc;
    logic [RES_W-1:0]  res;
    logic [AMT_W-1:0]  amount;
  } item_t;

  typedef struct packed {
    logic [PROC_W-1:0] proc_out;
    logic              deadlocked;
    logic              any_deadlock;
    logic              last;
  } result_t;

endpackage

/* rtl/dd_if.sv */
interface dd_in_if;
  logic                      valid;
  logic                      ready;
  dd_pkg::kind_t             kind;
  logic [dd_pkg::PROC_W-1:0] proc;
  logic [dd_pkg::RES_W-1:0]  res;
  logic [dd_pkg::AMT_W-1:0]  amount;

  modport source (output valid, kind, proc, res, amount, input ready);
  modport sink (input valid, kind, proc, res, amount, output ready);
endinterface

interface dd_out_if;
  logic                      valid;
  logic                      ready;
  logic [dd_pkg::PROC_W-1:0] proc_out;
  logic                      deadlocked;
  logic                      any_deadlock;
  logic                      last;

  modport source (output valid, proc_out, deadlocked, any_deadlock, last, input ready);
  modport sink (input valid, proc_out, deadlocked, any_deadlock, last, output ready);
endinterface

/* rtl/dd_ram.sv */
module dd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/dd_outbuf.sv */
module dd_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  dd_pkg::result_t      res,
  dd_out_if.source             out_chan
);

  logic            valid_r;
  logic            valid_nxt;
  dd_pkg::result_t data_r;

  assign res_ready = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.proc_out     = data_r.proc_out;
  assign out_chan.deadlocked   = data_r.deadlocked;
  assign out_chan.any_deadlock = data_r.any_deadlock;
  assign out_chan.last         = data_r.last;

endmodule

/* rtl/dd_engine.sv */
module dd_engine #(
  parameter int MAX_PROCS  = dd_pkg::MAX_PROCS_DEF,
  parameter int MAX_RES    = dd_pkg::MAX_RES_DEF,
  parameter int COUNT_BITS = dd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dd_pkg::CFG_DATA_W-1:0] num_procs,
  input  logic [dd_pkg::CFG_DATA_W-1:0] num_res,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dd_pkg::item_t                 item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output dd_pkg::result_t               res
);

  localparam int PW        = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW        = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int NPW       = $clog2(MAX_PROCS + 1);
  localparam int NRW       = $clog2(MAX_RES + 1);
  localparam int WW        = COUNT_BITS + 5;
  localparam int MAT_AW    = 1 + PW + RW;
  localparam int VEC_AW    = 1 + RW;
  localparam int MAT_DEPTH = 2 ** MAT_AW;
  localparam int VEC_DEPTH = 2 ** VEC_AW;

  dd_pkg::state_t          state_r, state_nxt;
  logic [NPW-1:0]          pc_r, pc_nxt;
  logic [NRW-1:0]          rc_r, rc_nxt;
  logic [NPW-1:0]          np_r, np_nxt;
  logic [NRW-1:0]          nr_r, nr_nxt;
  logic                    dv_r, dv_nxt;
  logic [RW-1:0]           dr_r, dr_nxt;
  logic                    fail_r, fail_nxt;
  logic                    prog_r, prog_nxt;
  logic [MAX_PROCS-1:0]    fin_r, fin_nxt;
  logic                    any_r, any_nxt;

  logic                    mat_we;
  logic [MAT_AW-1:0]       mat_waddr;
  logic [COUNT_BITS-1:0]   mat_wdata;
  logic [MAT_AW-1:0]       mat_raddr;
  logic [COUNT_BITS-1:0]   mat_rdata;
  logic                    vec_we;
  logic [VEC_AW-1:0]       vec_waddr;
  logic [WW-1:0]           vec_wdata;
  logic [VEC_AW-1:0]       vec_raddr;
  logic [WW-1:0]           vec_rdata;

  logic [COUNT_BITS-1:0]   amt_c;
  logic [NPW-1:0]          np_cfg;
  logic [NRW-1:0]          nr_cfg;
  logic                    proc_ok;
  logic                    res_ok;
  logic                    issue;
  logic                    adv;
  logic                    released;
  logic                    cmp_fail;
  logic                    pc_last;
  logic                    res_left;
  logic [WW:0]             sum;
  logic [MAX_PROCS-1:0]    live_unfin;
  logic                    any_now;

  dd_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAT_DEPTH)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  dd_ram #(
    .WIDTH (WW),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  assign amt_c    = COUNT_BITS'(item.amount);
  assign np_cfg   = (32'(num_procs) > MAX_PROCS) ? NPW'(MAX_PROCS) : NPW'(num_procs);
  assign nr_cfg   = (32'(num_res) > MAX_RES) ? NRW'(MAX_RES) : NRW'(num_res);
  assign proc_ok  = 32'(item.proc) < MAX_PROCS;
  assign res_ok   = 32'(item.res) < MAX_RES;
  assign pc_last  = (pc_r + NPW'(1)) == np_r;
  assign res_left = rc_r != nr_r;
  assign cmp_fail = dv_r && (WW'(mat_rdata) > vec_rdata);
  assign sum      = {1'b0, vec_rdata} + (WW + 1)'(mat_rdata);

  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      live_unfin[i] = !fin_r[i] && (32'(np_r) > i);
    end
  end

  assign any_now = |live_unfin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dd_pkg::ST_IDLE;
      dv_r    <= 1'b0;
      fin_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r   <= pc_nxt;
    rc_r   <= rc_nxt;
    np_r   <= np_nxt;
    nr_r   <= nr_nxt;
    dr_r   <= dr_nxt;
    fail_r <= fail_nxt;
    prog_r <= prog_nxt;
    any_r  <= any_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    rc_nxt    = rc_r;
    np_nxt    = np_r;
    nr_nxt    = nr_r;
    fail_nxt  = fail_r;
    prog_nxt  = prog_r;
    fin_nxt   = fin_r;
    any_nxt   = any_r;
    issue     = 1'b0;
    adv       = 1'b0;
    released  = 1'b0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    res.proc_out     = dd_pkg::PROC_W'(pc_r);
    res.deadlocked   = !fin_r[pc_r[PW-1:0]];
    res.any_deadlock = any_r;
    res.last         = pc_last;

    mat_we    = 1'b0;
    mat_waddr = {dd_pkg::MAT_SEL_ALLOC, PW'(item.proc), RW'(item.res)};
    mat_wdata = amt_c;
    mat_raddr = {dd_pkg::MAT_SEL_REQ, pc_r[PW-1:0], rc_r[RW-1:0]};
    vec_we    = 1'b0;
    vec_waddr = {dd_pkg::VEC_SEL_AVAIL, RW'(item.res)};
    vec_wdata = WW'(amt_c);
    vec_raddr = {dd_pkg::VEC_SEL_WORK, rc_r[RW-1:0]};

    case (state_r)
      dd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (item.kind)
            dd_pkg::KIND_AVAIL: begin
              vec_we = res_ok;
            end
            dd_pkg::KIND_ALLOC: begin
              mat_we = proc_ok && res_ok;
            end
            dd_pkg::KIND_REQ: begin
              mat_we    = proc_ok && res_ok;
              mat_waddr = {dd_pkg::MAT_SEL_REQ, PW'(item.proc), RW'(item.res)};
            end
            dd_pkg::KIND_RUN: begin
              np_nxt   = np_cfg;
              nr_nxt   = nr_cfg;
              pc_nxt   = '0;
              rc_nxt   = '0;
              fail_nxt = 1'b0;
              prog_nxt = 1'b0;
              fin_nxt  = '0;
              if (np_cfg != '0) begin
                state_nxt = dd_pkg::ST_COPY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dd_pkg::ST_COPY: begin
        vec_raddr = {dd_pkg::VEC_SEL_AVAIL, rc_r[RW-1:0]};
        if (dv_r) begin
          vec_we    = 1'b1;
          vec_waddr = {dd_pkg::VEC_SEL_WORK, dr_r};
          vec_wdata = vec_rdata;
        end
        if (res_left) begin
          issue  = 1'b1;
          rc_nxt = rc_r + NRW'(1);
        end else begin
          rc_nxt    = '0;
          fail_nxt  = 1'b0;
          state_nxt = dd_pkg::ST_SCAN;
        end
      end
      dd_pkg::ST_SCAN: begin
        if (fin_r[pc_r[PW-1:0]]) begin
          adv = 1'b1;
        end else begin
          fail_nxt = fail_r || cmp_fail;
          if (res_left) begin
            issue  = 1'b1;
            rc_nxt = rc_r + NRW'(1);
          end else if (fail_r || cmp_fail) begin
            adv = 1'b1;
          end else begin
            rc_nxt    = '0;
            state_nxt = dd_pkg::ST_RELEASE;
          end
        end
      end
      dd_pkg::ST_RELEASE: begin
        mat_raddr = {dd_pkg::MAT_SEL_ALLOC, pc_r[PW-1:0], rc_r[RW-1:0]};
        if (dv_r) begin
          vec_we    = 1'b1;
          vec_waddr = {dd_pkg::VEC_SEL_WORK, dr_r};
          vec_wdata = sum[WW] ? '1 : sum[WW-1:0];
        end
        if (res_left) begin
          issue  = 1'b1;
          rc_nxt = rc_r + NRW'(1);
        end else begin
          fin_nxt[pc_r[PW-1:0]] = 1'b1;
          released = 1'b1;
          adv      = 1'b1;
        end
      end
      dd_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (pc_last) begin
            pc_nxt    = '0;
            state_nxt = dd_pkg::ST_IDLE;
          end else begin
            pc_nxt = pc_r + NPW'(1);
          end
        end
      end
      default: begin
        state_nxt = dd_pkg::ST_IDLE;
      end
    endcase

    if (adv) begin
      rc_nxt   = '0;
      fail_nxt = 1'b0;
      if (pc_last) begin
        pc_nxt   = '0;
        prog_nxt = 1'b0;
        if (prog_r || released) begin
          state_nxt = dd_pkg::ST_SCAN;
        end else begin
          any_nxt   = any_now;
          state_nxt = dd_pkg::ST_EMIT;
        end
      end else begin
        pc_nxt    = pc_r + NPW'(1);
        prog_nxt  = prog_r || released;
        state_nxt = dd_pkg::ST_SCAN;
      end
    end

    dv_nxt = issue;
    dr_nxt = rc_r[RW-1:0];
  end

endmodule

/* rtl/deadlock_detector_core.sv */
// channel   dir  transfer on          payload
// in_chan   in   valid && ready       kind, proc, res, amount
// out_chan  out  valid && ready       proc_out, deadlocked, any_deadlock, last
// cfg       in   cfg_we               cfg_index, cfg_wdata
//
// a load item in range is written to memory as it is accepted; a run copies available into work,
// then tests the request of each unfinished process visited, skips a finished one
// and releases the allocation of a fitting one, over up to np+1 passes, then gives one
// result per process; the single read port of each memory sets the per-resource step
// reset sets num_procs and num_res to 16, empties the output register, leaves memories as is
// in_chan.ready stays low from a run until its last result sits in the output register;
// an output stall holds the result walk
module deadlock_detector_core #(
  parameter int MAX_PROCS  = dd_pkg::MAX_PROCS_DEF,
  parameter int MAX_RES    = dd_pkg::MAX_RES_DEF,
  parameter int COUNT_BITS = dd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dd_in_if.sink                         in_chan,
  dd_out_if.source                      out_chan
);

  logic [dd_pkg::CFG_DATA_W-1:0] num_procs_r, num_procs_nxt;
  logic [dd_pkg::CFG_DATA_W-1:0] num_res_r, num_res_nxt;
  dd_pkg::item_t                 item;
  dd_pkg::result_t               res;
  logic                          res_valid;
  logic                          res_ready;

  always_comb begin
    num_procs_nxt = num_procs_r;
    num_res_nxt   = num_res_r;
    if (cfg_we) begin
      case (cfg_index)
        dd_pkg::CFG_NUM_PROCS: num_procs_nxt = cfg_wdata;
        dd_pkg::CFG_NUM_RES:   num_res_nxt   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_procs_r <= dd_pkg::NUM_PROCS_RST;
      num_res_r   <= dd_pkg::NUM_RES_RST;
    end else begin
      num_procs_r <= num_procs_nxt;
      num_res_r   <= num_res_nxt;
    end
  end

  assign item.kind   = in_chan.kind;
  assign item.proc   = in_chan.proc;
  assign item.res    = in_chan.res;
  assign item.amount = in_chan.amount;

  dd_engine #(
    .MAX_PROCS  (MAX_PROCS),
    .MAX_RES    (MAX_RES),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_procs (num_procs_r),
    .num_res   (num_res_r),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  dd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_chan  (out_chan)
  );

endmodule

/* sim/deadlock_detector_core_tb.sv */
`timescale 1ns / 1ps

module deadlock_detector_core_tb;

  localparam int CLK_HALF      = 10;
  localparam int TAB_N         = 16;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int DIR_ROWS      = 24;

  localparam int PROC_W     = dd_pkg::PROC_W;
  localparam int RES_W      = dd_pkg::RES_W;
  localparam int AMT_W      = dd_pkg::AMT_W;
  localparam int CFG_IDX_W  = dd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = dd_pkg::CFG_DATA_W;

  typedef dd_pkg::kind_t   kind_t;
  typedef dd_pkg::result_t result_t;

  localparam kind_t KIND_AVAIL = dd_pkg::KIND_AVAIL;
  localparam kind_t KIND_ALLOC = dd_pkg::KIND_ALLOC;
  localparam kind_t KIND_REQ   = dd_pkg::KIND_REQ;
  localparam kind_t KIND_RUN   = dd_pkg::KIND_RUN;

  localparam logic [CFG_IDX_W-1:0]  CFG_NUM_PROCS = dd_pkg::CFG_NUM_PROCS;
  localparam logic [CFG_IDX_W-1:0]  CFG_NUM_RES   = dd_pkg::CFG_NUM_RES;
  localparam logic [CFG_DATA_W-1:0] NUM_PROCS_RST = dd_pkg::NUM_PROCS_RST;
  localparam logic [CFG_DATA_W-1:0] NUM_RES_RST   = dd_pkg::NUM_RES_RST;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;
  typedef enum logic [1:0] {IDLE_SRC_LIGHT, IDLE_SRC_HEAVY, IDLE_NONE} idle_mode_t;

  typedef struct {
    row_op_t               op;
    kind_t                 kind;
    logic [PROC_W-1:0]     proc;
    logic [RES_W-1:0]      res;
    logic [AMT_W-1:0]      amount;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    bit                    typed;
    logic [TAB_N-1:0]      dead_mask;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dd_in_if  in_if();
  dd_out_if out_if();

  deadlock_detector_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // predictor copy of the block's configuration and tables
  logic [CFG_DATA_W-1:0] procs_reg;
  logic [CFG_DATA_W-1:0] res_reg;
  bit [AMT_W-1:0] avail_tab [TAB_N];
  bit [AMT_W-1:0] held_tab  [TAB_N][TAB_N];
  bit [AMT_W-1:0] asked_tab [TAB_N][TAB_N];
  bit             avail_set [TAB_N];
  bit             held_set  [TAB_N][TAB_N];
  bit             asked_set [TAB_N][TAB_N];

  result_t     due_results [$];
  int unsigned fails;
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned hold_left;
  idle_mode_t  idle_mode;

  logic [CFG_DATA_W-1:0] ph_procs [PHASES] = '{5'd3, 5'd31, 5'd4, 5'd1, 5'd0, 5'd6, 5'd16, 5'd2};
  logic [CFG_DATA_W-1:0] ph_res   [PHASES] = '{5'd2, 5'd1, 5'd3, 5'd16, 5'd5, 5'd0, 5'd2, 5'd20};

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_CFG,  KIND_AVAIL, 4'd0,  4'd0,  12'd0,    CFG_NUM_PROCS, 5'd2, 1'b0, 16'h0},
    '{ROW_CFG,  KIND_AVAIL, 4'd0,  4'd0,  12'd0,    CFG_NUM_RES,   5'd2, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_AVAIL, 4'd15, 4'd0,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_AVAIL, 4'd0,  4'd1,  12'd4095, CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_AVAIL, 4'd9,  4'd15, 12'h5a5,  CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_ALLOC, 4'd0,  4'd0,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_ALLOC, 4'd0,  4'd1,  12'd4095, CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_ALLOC, 4'd1,  4'd0,  12'd4095, CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_ALLOC, 4'd1,  4'd1,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_REQ,   4'd0,  4'd0,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_REQ,   4'd0,  4'd1,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_REQ,   4'd1,  4'd0,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_REQ,   4'd1,  4'd1,  12'd4095, CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_RUN,   4'd15, 4'd15, 12'd4095, CFG_NUM_PROCS, 5'd0, 1'b1, 16'h0},
    '{ROW_ITEM, KIND_REQ,   4'd0,  4'd0,  12'd4095, CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_RUN,   4'd0,  4'd0,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_REQ,   4'd1,  4'd0,  12'd1,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    // neither request fits the starting work
    '{ROW_ITEM, KIND_RUN,   4'd6,  4'd9,  12'h3c3,  CFG_NUM_PROCS, 5'd0, 1'b1, 16'h3},
    // no resource types in use: every request fits
    '{ROW_CFG,  KIND_AVAIL, 4'd0,  4'd0,  12'd0,    CFG_NUM_RES,   5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_RUN,   4'd3,  4'd12, 12'hc3c,  CFG_NUM_PROCS, 5'd0, 1'b1, 16'h0},
    // no processes: run gives no results
    '{ROW_CFG,  KIND_AVAIL, 4'd0,  4'd0,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_RUN,   4'd0,  4'd0,  12'd0,    CFG_NUM_PROCS, 5'd0, 1'b1, 16'h0},
    '{ROW_ITEM, KIND_ALLOC, 4'd15, 4'd15, 12'ha5a,  CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0},
    '{ROW_ITEM, KIND_REQ,   4'd10, 4'd5,  12'h800,  CFG_NUM_PROCS, 5'd0, 1'b0, 16'h0}
  };

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic int unsigned cap_count(logic [CFG_DATA_W-1:0] v);
    return (v > TAB_N) ? TAB_N : int'(v);
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount(int unsigned span);
    return ($urandom_range(0, 9) == 0) ? AMT_W'($urandom) : AMT_W'($urandom_range(0, span));
  endfunction

  // greedy safety walk: lowest fitting unfinished process releases its allocation
  function automatic logic [TAB_N-1:0] find_deadlocked();
    int unsigned      np;
    int unsigned      nr;
    logic [16:0]      work [TAB_N];
    logic [17:0]      sum;
    bit               done [TAB_N];
    bit               moved;
    bit               fit;
    logic [TAB_N-1:0] dead;
    np = cap_count(procs_reg);
    nr = cap_count(res_reg);
    dead = '0;
    for (int r = 0; r < TAB_N; r++) begin
      work[r] = 17'(avail_tab[r]);
      done[r] = 1'b0;
    end
    do begin
      moved = 1'b0;
      for (int p = 0; p < np && !moved; p++) begin
        if (!done[p]) begin
          fit = 1'b1;
          for (int r = 0; r < nr; r++)
            if (17'(asked_tab[p][r]) > work[r]) fit = 1'b0;
          if (fit) begin
            for (int r = 0; r < nr; r++) begin
              sum = 18'(work[r]) + 18'(held_tab[p][r]);
              work[r] = (sum > 18'h1ffff) ? 17'h1ffff : sum[16:0];
            end
            done[p] = 1'b1;
            moved = 1'b1;
          end
        end
      end
    end while (moved);
    for (int p = 0; p < np; p++) dead[p] = !done[p];
    return dead;
  endfunction

  function automatic void issue_results(logic [TAB_N-1:0] dead);
    int unsigned np;
    bit          any;
    result_t     res_item;
    np = cap_count(procs_reg);
    any = 1'b0;
    for (int p = 0; p < np; p++) any |= dead[p];
    for (int p = 0; p < np; p++) begin
      res_item.proc_out = PROC_W'(p);
      res_item.deadlocked = dead[p];
      res_item.any_deadlock = any;
      res_item.last = (p == np - 1);
      due_results.push_back(res_item);
    end
  endfunction

  task automatic put_item(kind_t k, logic [PROC_W-1:0] p, logic [RES_W-1:0] r,
                          logic [AMT_W-1:0] a, bit typed = 1'b0,
                          logic [TAB_N-1:0] mask = '0);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SRC_LIGHT) ? 14 : (idle_mode == IDLE_SRC_HEAVY) ? 77 : 0;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= k;
    in_if.proc   <= p;
    in_if.res    <= r;
    in_if.amount <= a;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    case (k)
      KIND_AVAIL: begin
        avail_tab[r] = a;
        avail_set[r] = 1'b1;
      end
      KIND_ALLOC: begin
        held_tab[p][r] = a;
        held_set[p][r] = 1'b1;
      end
      KIND_REQ: begin
        asked_tab[p][r] = a;
        asked_set[p][r] = 1'b1;
      end
      default: begin
        if (typed) issue_results(mask);
        else issue_results(find_deadlocked());
      end
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NUM_PROCS: procs_reg = val;
      CFG_NUM_RES:   res_reg = val;
      default: ;
    endcase
  endtask

  // load every entry the next run will read, then start it
  task automatic send_run();
    int unsigned np;
    int unsigned nr;
    np = cap_count(procs_reg);
    nr = cap_count(res_reg);
    if (np == 0) np = 1;
    if (nr == 0) nr = 1;
    for (int r = 0; r < nr; r++)
      if (!avail_set[r]) put_item(KIND_AVAIL, PROC_W'($urandom), RES_W'(r), pick_amount(7));
    for (int p = 0; p < np; p++) begin
      for (int r = 0; r < nr; r++) begin
        if (!held_set[p][r])
          put_item(KIND_ALLOC, PROC_W'(p), RES_W'(r), pick_amount(3));
        if (!asked_set[p][r])
          put_item(KIND_REQ, PROC_W'(p), RES_W'(r), pick_amount(6));
      end
    end
    put_item(KIND_RUN, PROC_W'($urandom), RES_W'($urandom), AMT_W'($urandom));
  endtask

  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_SRC_LIGHT: out_if.ready <= ($urandom_range(0, 99) >= 77);
        IDLE_SRC_HEAVY: out_if.ready <= ($urandom_range(0, 99) >= 14);
        default:        out_if.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: proc_out %0d", out_if.proc_out);
        fails++;
      end else begin
        want = due_results.pop_front();
        if (out_if.proc_out !== want.proc_out) begin
          $error("proc_out: expected %0d, got %0d", want.proc_out, out_if.proc_out);
          fails++;
        end
        if (out_if.deadlocked !== want.deadlocked) begin
          $error("deadlocked: expected %0d, got %0d", want.deadlocked, out_if.deadlocked);
          fails++;
        end
        if (out_if.any_deadlock !== want.any_deadlock) begin
          $error("any_deadlock: expected %0d, got %0d", want.any_deadlock,
                 out_if.any_deadlock);
          fails++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_if.last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("deadlock_detector_core: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned np;
    int unsigned nr;
    int unsigned phase_start;
    kind_t       k;
    bit          paused;
    fails = 0;
    items_sent = 0;
    cycles = 0;
    hold_reqs = 0;
    hold_seen = 0;
    hold_left = 0;
    paused = 1'b0;
    idle_mode = IDLE_SRC_LIGHT;
    procs_reg = NUM_PROCS_RST;
    res_reg = NUM_RES_RST;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_AVAIL;
    in_if.proc = '0;
    in_if.res = '0;
    in_if.amount = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG)
        write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
      else
        put_item(dir_tab[i].kind, dir_tab[i].proc, dir_tab[i].res, dir_tab[i].amount,
                 dir_tab[i].typed, dir_tab[i].dead_mask);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_mode = (ph < 3) ? IDLE_SRC_LIGHT : (ph < 6) ? IDLE_SRC_HEAVY : IDLE_NONE;
      write_reg(CFG_NUM_PROCS, ph_procs[ph]);
      write_reg(CFG_NUM_RES, ph_res[ph]);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        np = cap_count(procs_reg);
        nr = cap_count(res_reg);
        k = kind_t'($urandom_range(0, 2));
        if (roll < 12) begin
          put_item(k, PROC_W'($urandom), RES_W'($urandom), AMT_W'($urandom));
        end else if (roll < 75) begin
          put_item(k,
                   (np == 0) ? PROC_W'($urandom) : PROC_W'($urandom_range(0, np - 1)),
                   (nr == 0) ? RES_W'($urandom) : RES_W'($urandom_range(0, nr - 1)),
                   pick_amount((k == KIND_ALLOC) ? 3 : 7));
        end else begin
          send_run();
          // long output stall right behind a run so the input backs up
          if (ph == 0 && hold_reqs == 0) hold_reqs++;
          if (ph == 3 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
            paused = 1'b1;
            drain();
          end
        end
      end
      send_run();
    end

    drain();
    if (fails == 0) begin
      $display("deadlock_detector_core: match");
    end else begin
      $display("deadlock_detector_core: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dd_pkg.sv
rtl/dd_if.sv
rtl/dd_ram.sv
rtl/dd_outbuf.sv
rtl/dd_engine.sv
rtl/deadlock_detector_core.sv
sim/deadlock_detector_core_tb.sv
